// ===== hw/rtl/hof_pkg.sv =====
package hof_pkg;

  localparam int WINDOW_DEF = 7;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int COUNT_W    = 32;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  localparam logic [CFG_W-1:0] GAIN_RESET = 16'd1139;
  localparam logic [CFG_W-1:0] MIN_RESET  = 16'd8;

  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN  = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT1,
    ST_MED,
    ST_DEV,
    ST_SORT2,
    ST_MAD,
    ST_MULT,
    ST_DECIDE,
    ST_EMIT
  } hof_state_t;

  typedef struct packed {
    logic accept;
    logic load_sort;
    logic sort_step;
    logic sort_odd;
    logic lat_med;
    logic load_dev;
    logic lat_mad;
    logic mult;
    logic decide;
    logic out_load;
  } hof_cmd_t;

  typedef struct packed {
    logic primed;
    logic out_busy;
  } hof_stat_t;

endpackage

// ===== hw/rtl/hof_ctrl.sv =====
module hof_ctrl #(
  parameter int WINDOW = hof_pkg::WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  hof_pkg::hof_stat_t stat,
  output hof_pkg::hof_cmd_t  cmd
);
  import hof_pkg::*;

  localparam int PASS_W = $clog2(WINDOW);
  localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(WINDOW - 1);

  hof_state_t state_r, state_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.primed ? ST_LOAD : ST_EMIT;
        end
      end
      ST_LOAD: begin
        cmd.load_sort = 1'b1;
        pass_nxt      = '0;
        state_nxt     = ST_SORT1;
      end
      ST_SORT1: begin
        cmd.sort_step = 1'b1;
        cmd.sort_odd  = pass_r[0];
        pass_nxt      = pass_r + 1'b1;
        if (pass_r == LAST_PASS) state_nxt = ST_MED;
      end
      ST_MED: begin
        cmd.lat_med = 1'b1;
        state_nxt   = ST_DEV;
      end
      ST_DEV: begin
        cmd.load_dev = 1'b1;
        pass_nxt     = '0;
        state_nxt    = ST_SORT2;
      end
      ST_SORT2: begin
        cmd.sort_step = 1'b1;
        cmd.sort_odd  = pass_r[0];
        pass_nxt      = pass_r + 1'b1;
        if (pass_r == LAST_PASS) state_nxt = ST_MAD;
      end
      ST_MAD: begin
        cmd.lat_mad = 1'b1;
        state_nxt   = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/hof_datapath.sv =====
module hof_datapath #(
  parameter int WINDOW = hof_pkg::WINDOW_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hof_pkg::hof_cmd_t                     cmd,
  output hof_pkg::hof_stat_t                    stat,
  input  logic signed [hof_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                  cfg_we,
  input  logic [hof_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [hof_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [hof_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [hof_pkg::OUT_USER_W-1:0]        out_tuser
);
  import hof_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int HALF   = WINDOW / 2;
  localparam int MID_LO = WINDOW / 2 - 1;
  localparam bit IS_EVEN = (WINDOW % 2) == 0;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [SLOT_W:0]   HALF_X    = (SLOT_W + 1)'(HALF);
  localparam logic [SLOT_W:0]   WIN_X     = (SLOT_W + 1)'(WINDOW);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW);

  logic signed [SAMPLE_W-1:0] win_r [WINDOW];
  logic signed [SAMPLE_W:0]   sort_r [WINDOW];
  logic signed [SAMPLE_W:0]   sort_nxt [WINDOW];

  logic [SLOT_W-1:0]   slot_r;
  logic [FILL_W-1:0]   fill_r;
  logic [COUNT_W-1:0]  count_r;
  logic [CFG_W-1:0]    gain_r, min_r;
  logic signed [SAMPLE_W-1:0] med_r;
  logic [SAMPLE_W-1:0] mad_r;
  logic [31:0]         prod_r;

  logic signed [SAMPLE_W-1:0] res_sample_r;
  logic                res_outlier_r, res_primed_r;

  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic [SLOT_W:0]     centre_sum;
  logic [SLOT_W-1:0]   centre;
  logic signed [SAMPLE_W-1:0] centre_val;
  logic [SAMPLE_W-1:0] centre_dev;
  logic [23:0]         thr_raw, thr;
  logic                replace_hit;
  logic signed [SAMPLE_W+1:0] mid_sum;
  logic [SAMPLE_W-1:0] mid_c;

  function automatic logic [SAMPLE_W-1:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                   input logic signed [SAMPLE_W-1:0] b);
    logic signed [SAMPLE_W:0] d;
    d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    abs_diff = d[SAMPLE_W] ? SAMPLE_W'(-d) : d[SAMPLE_W-1:0];
  endfunction

  // centre slot relative to the already advanced write slot
  assign centre_sum = {1'b0, slot_r} + HALF_X;
  assign centre     = (centre_sum >= WIN_X) ? SLOT_W'(centre_sum - WIN_X)
                                            : centre_sum[SLOT_W-1:0];
  assign centre_val = win_r[centre];
  assign centre_dev = abs_diff(centre_val, med_r);
  assign thr_raw    = prod_r[31:8];
  assign thr        = (thr_raw < {8'd0, min_r}) ? {8'd0, min_r} : thr_raw;
  assign replace_hit = {8'd0, centre_dev} > thr;

  // middle of the sorted row; even window takes floor of the pair average
  assign mid_sum = {sort_r[MID_LO][SAMPLE_W], sort_r[MID_LO]}
                 + {sort_r[HALF][SAMPLE_W], sort_r[HALF]};
  assign mid_c   = IS_EVEN ? mid_sum[SAMPLE_W:1] : sort_r[HALF][SAMPLE_W-1:0];

  // one odd-even transposition pass; pairs of one parity are disjoint
  always_comb begin
    for (int i = 0; i < WINDOW; i++) sort_nxt[i] = sort_r[i];
    for (int i = 0; i < WINDOW - 1; i++) begin
      if ((i[0] == cmd.sort_odd) && (sort_r[i] > sort_r[i+1])) begin
        sort_nxt[i]   = sort_r[i+1];
        sort_nxt[i+1] = sort_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sort) begin
      for (int i = 0; i < WINDOW; i++) sort_r[i] <= {win_r[i][SAMPLE_W-1], win_r[i]};
    end else if (cmd.load_dev) begin
      for (int i = 0; i < WINDOW; i++) sort_r[i] <= {1'b0, abs_diff(win_r[i], med_r)};
    end else if (cmd.sort_step) begin
      for (int i = 0; i < WINDOW; i++) sort_r[i] <= sort_nxt[i];
    end
    if (cmd.accept) win_r[slot_r] <= in_sample;
    else if (cmd.decide && replace_hit) win_r[centre] <= med_r;
    if (cmd.lat_med) med_r <= mid_c;
    if (cmd.lat_mad) mad_r <= mid_c;
    if (cmd.mult) prod_r <= gain_r * mad_r;
    if (cmd.accept) begin
      res_sample_r  <= in_sample;
      res_outlier_r <= 1'b0;
      res_primed_r  <= 1'b0;
    end else if (cmd.decide) begin
      res_sample_r  <= replace_hit ? med_r : centre_val;
      res_outlier_r <= replace_hit;
      res_primed_r  <= 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r <= {count_r, res_sample_r};
      out_user_r <= {res_primed_r, res_outlier_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      gain_r      <= GAIN_RESET;
      min_r       <= MIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
        if (fill_r != FULL) fill_r <= fill_r + 1'b1;
      end
      if (cmd.decide && replace_hit) count_r <= count_r + 1'b1;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAIN: gain_r <= cfg_wdata;
          CFG_MIN:  min_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign stat.primed   = (fill_r == FULL);
  assign stat.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hw/rtl/hampel_outlier_filter_unit.sv =====
// Channel  Dir  Signals                            Content (low bit up)
// in_      in   in_tvalid/in_tready/in_tdata       tdata[15:0] sample_in
// out_     out  out_tvalid/out_tready/out_tdata    tdata[15:0] sample_out, [47:16] outlier_total
//                out_tuser                          tuser[0] outlier, [1] primed
// cfg_     in   cfg_we/cfg_addr/cfg_wdata          0 threshold_gain, 1 min_threshold
//
// A filtering sample runs through the odd-even transposition sorter, one pass per cycle,
// twice: on the window for the median, then on the deviations for the MAD.
// While the window fills a sample skips the sorter and goes straight to the output.
// One sample is in work at a time; the next is accepted while a result waits.
// A stalled result holds in the output register; reset is synchronous, active low.
module hampel_outlier_filter_unit #(
  parameter int WINDOW = hof_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hof_pkg::SAMPLE_W-1:0]       in_tdata,   // [15:0] sample_in
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hof_pkg::OUT_DATA_W-1:0]     out_tdata,  // [15:0] sample_out, [47:16] outlier_total
  output logic [hof_pkg::OUT_USER_W-1:0]     out_tuser,  // [0] outlier, [1] primed
  input  logic                               cfg_we,
  input  logic [hof_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [hof_pkg::CFG_W-1:0]          cfg_wdata
);
  import hof_pkg::*;

  hof_cmd_t  cmd;
  hof_stat_t stat;

  hof_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hof_datapath #(.WINDOW(WINDOW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_sample  (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/hof_checker.sv =====
module hof_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [hof_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [hof_pkg::OUT_USER_W-1:0]     out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed under stall");

  // replacement only happens once the window is full
  a_outlier_primed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("outlier flagged on unprimed result");

  // one sample in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind hampel_outlier_filter_unit hof_checker u_hof_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hof_pkg::*;

  localparam int WIN        = WINDOW_DEF;
  localparam int STALL_MAX  = 8;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYC   = 2 * WIN + 20;
  localparam int CHUNKS     = 10;
  localparam int CHUNK_LEN  = 120;

  // Address slots past the register list; writes there must be dropped.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE3 = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       outlier;
    logic                       primed;
    logic [COUNT_W-1:0]         total;
  } filtered_t;

  typedef longint win_arr_t [WIN];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  hampel_outlier_filter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [15:0] sample_in
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [15:0] sample_out, [47:16] outlier_total
    .out_tuser (out_tuser),   // [0] outlier, [1] primed
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- filter prediction ----------------
  logic signed [SAMPLE_W-1:0] win_buf [WIN];
  int unsigned wr_slot;
  int unsigned fill_cnt;
  logic [COUNT_W-1:0] outlier_cnt;
  logic [CFG_W-1:0] gain_q88;
  logic [CFG_W-1:0] thr_floor;

  filtered_t filtered_q [$];

  bit in_gaps;
  bit out_gaps;
  int rx_hold_req;
  int walk_level;
  int noise_span;

  int n_sent;
  int n_results;
  int n_flagged;
  int n_cfg_writes;
  int n_mismatches;
  int idle_cycles;

  // sort, then middle value; even sizes average the middle pair, floored
  function automatic longint window_mid(input win_arr_t v);
    win_arr_t s;
    longint key;
    int i;
    int j;
    s = v;
    for (i = 1; i < WIN; i++) begin
      key = s[i];
      j = i;
      while (j > 0 && s[j-1] > key) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = key;
    end
    if (WIN % 2 == 0) return (s[WIN/2-1] + s[WIN/2]) >>> 1;
    return s[WIN/2];
  endfunction

  function automatic void hampel_reset();
    int i;
    for (i = 0; i < WIN; i++) win_buf[i] = '0;
    wr_slot = 0;
    fill_cnt = 0;
    outlier_cnt = '0;
    gain_q88 = GAIN_RESET;
    thr_floor = MIN_RESET;
  endfunction

  function automatic void hampel_predict(input logic signed [SAMPLE_W-1:0] smp);
    win_arr_t vals;
    filtered_t r;
    longint med;
    longint mad;
    longint thr;
    longint cdev;
    int unsigned centre;
    int i;
    win_buf[wr_slot] = smp;
    wr_slot = (wr_slot + 1) % WIN;
    r.sample = smp;
    r.outlier = 1'b0;
    r.primed = 1'b0;
    if (fill_cnt < WIN) begin
      fill_cnt++;
    end else begin
      for (i = 0; i < WIN; i++) vals[i] = longint'(win_buf[i]);
      med = window_mid(vals);
      for (i = 0; i < WIN; i++) begin
        vals[i] = (vals[i] >= med) ? vals[i] - med : med - vals[i];
      end
      mad = window_mid(vals);
      thr = (longint'(gain_q88) * mad) >>> 8;
      if (thr < longint'(thr_floor)) thr = longint'(thr_floor);
      centre = (wr_slot + WIN / 2) % WIN;
      cdev = longint'(win_buf[centre]) - med;
      if (cdev < 0) cdev = -cdev;
      r.primed = 1'b1;
      if (cdev > thr) begin
        r.outlier = 1'b1;
        outlier_cnt = outlier_cnt + 1;
        win_buf[centre] = med[SAMPLE_W-1:0];
        r.sample = med[SAMPLE_W-1:0];
      end else begin
        r.sample = win_buf[centre];
      end
    end
    r.total = outlier_cnt;
    filtered_q.push_back(r);
  endfunction

  // random walk with noise, spikes and the odd wild value
  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    walk_level = walk_level + int'($urandom_range(0, 64)) - 32;
    if (walk_level > 30000) walk_level = 30000;
    if (walk_level < -30000) walk_level = -30000;
    if (pick < 6) return SAMPLE_W'($urandom);
    if (pick < 16) begin
      v = int'($urandom_range(100, 40000));
      v = ($urandom_range(0, 1) != 0) ? walk_level + v : walk_level - v;
    end else begin
      v = walk_level + int'($urandom_range(0, 2 * noise_span)) - noise_span;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  // ---------------- stimulus side ----------------
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = in_gaps ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    do @(posedge clk); while (in_tready !== 1'b1);
    hampel_predict(smp);
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_GAIN: gain_q88 = data;
      CFG_MIN:  thr_floor = data;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(next_sample());
  endtask

  // ---------------- result side ----------------
  initial begin
    int stall;
    int hold;
    forever begin
      if (rx_hold_req > 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      stall = out_gaps ? $urandom_range(0, STALL_MAX) : 0;
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    filtered_t want;
    logic signed [SAMPLE_W-1:0] got_smp;
    logic [COUNT_W-1:0] got_total;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got_smp = out_tdata[SAMPLE_W-1:0];
      got_total = out_tdata[SAMPLE_W +: COUNT_W];
      n_results++;
      if (out_tuser[0]) n_flagged++;
      if (filtered_q.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= 10)
          $display("[%0t] unexpected result: sample %0d outlier %0b primed %0b total %0d",
                   $realtime, got_smp, out_tuser[0], out_tuser[1], got_total);
      end else begin
        want = filtered_q.pop_front();
        if (got_smp !== want.sample || out_tuser[0] !== want.outlier ||
            out_tuser[1] !== want.primed || got_total !== want.total) begin
          n_mismatches++;
          if (n_mismatches <= 10)
            $display("[%0t] mismatch: exp sample %0d outlier %0b primed %0b total %0d,",
                     $realtime, want.sample, want.outlier, want.primed, want.total,
                     " got sample %0d outlier %0b primed %0b total %0d",
                     got_smp, out_tuser[0], out_tuser[1], got_total);
        end
      end
    end
  end

  // no transaction on either side for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 IDLE_LIMIT, filtered_q.size());
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  // pass-through while filling, full-scale values, threshold at and just past the floor
  task automatic test_fill_and_extremes();
    logic signed [SAMPLE_W-1:0] seq [25];
    int i;
    seq = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1, 16'sd100, 16'sd100,
            16'sd100, 16'sd100, 16'sd108, 16'sd100, 16'sd100, 16'sd100, 16'sd109,
            16'sd100, 16'sd100, 16'sd100, 16'sd32767, 16'sd100, 16'sd100, 16'sd100,
            -16'sd32768, 16'sd100, 16'sd100, 16'sd100};
    for (i = 0; i < 25; i++) send_sample(seq[i]);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    cfg_write(CFG_GAIN, 16'h0000);
    cfg_write(CFG_MIN, 16'h0000);
    send_random(30);
    cfg_write(CFG_GAIN, 16'hFFFF);
    cfg_write(CFG_MIN, 16'hFFFF);
    send_random(30);
    cfg_write(CFG_MIN, 16'h0000);
    cfg_write(CFG_SPARE2, CFG_W'($urandom));
    send_random(30);
    cfg_write(CFG_GAIN, 16'h0000);
    cfg_write(CFG_MIN, 16'hFFFF);
    cfg_write(CFG_SPARE3, CFG_W'($urandom));
    send_random(30);
    cfg_write(CFG_GAIN, GAIN_RESET);
    cfg_write(CFG_MIN, MIN_RESET);
  endtask

  // receiver holds off while the sender keeps pushing: input must stall
  task automatic test_backpressure();
    in_gaps = 0;
    rx_hold_req = HOLD_LEN;
    send_random(24);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    in_gaps = 1;
    out_gaps = 1;
    send_random(12);
    wait_drained();
    send_random(12);
    wait_drained();
  endtask

  task automatic test_random_stream();
    int c;
    for (c = 0; c < CHUNKS; c++) begin
      case (c % 4)
        0: begin
          cfg_write(CFG_GAIN, CFG_W'($urandom_range(256, 2048)));
          cfg_write(CFG_MIN, CFG_W'($urandom_range(0, 64)));
        end
        1: begin
          cfg_write(CFG_GAIN, CFG_W'($urandom));
          cfg_write(CFG_MIN, CFG_W'($urandom));
        end
        2: begin
          cfg_write(CFG_GAIN, CFG_W'($urandom_range(0, 300)));
          cfg_write(CFG_MIN, CFG_W'($urandom_range(0, 16)));
          cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE2 : CFG_SPARE3,
                    CFG_W'($urandom));
        end
        default: ;
      endcase
      in_gaps = ($urandom_range(0, 2) != 0);
      out_gaps = ($urandom_range(0, 2) != 0);
      noise_span = ($urandom_range(0, 3) == 0) ? 1 : int'($urandom_range(4, 200));
      send_random(CHUNK_LEN);
    end
    wait_drained();
  endtask

  initial begin
    hampel_reset();
    in_gaps = 1;
    out_gaps = 1;
    rx_hold_req = 0;
    walk_level = 0;
    noise_span = 20;
    n_sent = 0;
    n_results = 0;
    n_flagged = 0;
    n_cfg_writes = 0;
    n_mismatches = 0;
    idle_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_extremes();
    test_config_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_stream();

    wait_drained();
    repeat (TAIL_CYC) @(posedge clk);
    if (filtered_q.size() != 0) begin
      $display("%0d expected results never arrived", filtered_q.size());
      n_mismatches++;
    end
    $display("Sent %0d samples and checked %0d results (%0d flagged as outliers)",
             n_sent, n_results, n_flagged);
    $display("across %0d register writes, with stalls on both sides; %0d mismatches",
             n_cfg_writes, n_mismatches);
    if (n_mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hof_pkg.sv
hw/rtl/hof_ctrl.sv
hw/rtl/hof_datapath.sv
hw/rtl/hampel_outlier_filter_unit.sv
hw/rtl/hof_checker.sv
tb/tb_top.sv
